>>> design/smmv_pkg.sv
package smmv_pkg;

	localparam int CAPACITY    = 16;
	localparam int SAMPLE_BITS = 16;
	localparam int FRAC_BITS   = 8;

	// accumulator widths
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int SUM_W = SAMPLE_BITS + CNT_W;
	localparam int SQS_W = 2 * SAMPLE_BITS + CNT_W - 2;
	localparam int NUM_W = SQS_W + CNT_W - 1;
	localparam int NSQ_W = 2 * CNT_W - 1;
	localparam int PRD_W = 2 * SUM_W;

	// result field widths
	localparam int MEAN_W = 24;
	localparam int VAR_W  = 39;
	localparam int STD_W  = 24;
	localparam int OCNT_W = 5;

	// shared subtract unit and the long division / root loops
	localparam int MEAN_STEPS = SUM_W - 1 + FRAC_BITS;
	localparam int RAD_W      = 2 * ((NUM_W + FRAC_BITS + 1) / 2);
	localparam int VAR_STEPS  = RAD_W;
	localparam int ROOT_STEPS = RAD_W / 2;
	localparam int UNIT_W     = ROOT_STEPS + 4;
	localparam int ITER_W     = $clog2(RAD_W + 1);

	typedef struct packed {
		logic [UNIT_W-1:0] a;
		logic [UNIT_W-1:0] b;
	} step_req_t;

	typedef struct packed {
		logic [UNIT_W-1:0] diff;
		logic              ge;
	} step_rsp_t;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] largest;
		logic signed [SAMPLE_BITS-1:0] smallest;
		logic signed [MEAN_W-1:0]      mean_fx;
		logic [VAR_W-1:0]              variance_fx;
		logic [STD_W-1:0]              std_dev_fx;
		logic [OCNT_W-1:0]             sample_count;
		logic                          dropped;
	} stats_t;

endpackage

>>> design/smmv_if.sv
interface smmv_in_if;
	import smmv_pkg::*;

	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample;
	logic                          is_last;

	modport source (output valid, output sample, output is_last, input ready);
	modport sink (input valid, input sample, input is_last, output ready);
endinterface

interface smmv_out_if;
	import smmv_pkg::*;

	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] largest;
	logic signed [SAMPLE_BITS-1:0] smallest;
	logic signed [MEAN_W-1:0]      mean_fx;
	logic [VAR_W-1:0]              variance_fx;
	logic [STD_W-1:0]              std_dev_fx;
	logic [OCNT_W-1:0]             sample_count;
	logic                          dropped;

	modport source (output valid, output largest, output smallest, output mean_fx,
		output variance_fx, output std_dev_fx, output sample_count, output dropped,
		input ready);
	modport sink (input valid, input largest, input smallest, input mean_fx,
		input variance_fx, input std_dev_fx, input sample_count, input dropped,
		output ready);
endinterface

>>> design/smmv_sub.sv
module smmv_sub (
	input  smmv_pkg::step_req_t req,
	output smmv_pkg::step_rsp_t rsp
);
	import smmv_pkg::*;

	logic [UNIT_W:0] diff_ext;

	assign diff_ext = {1'b0, req.a} - {1'b0, req.b};
	assign rsp.diff = diff_ext[UNIT_W-1:0];
	assign rsp.ge   = ~diff_ext[UNIT_W];
endmodule

>>> design/smmv_core.sv
module smmv_core (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    in_valid,
	output logic                                    in_ready,
	input  logic signed [smmv_pkg::SAMPLE_BITS-1:0] in_sample,
	input  logic                                    in_last,
	output logic                                    res_valid,
	input  logic                                    res_ready,
	output smmv_pkg::stats_t                        res,
	output smmv_pkg::step_req_t                     step_req,
	input  smmv_pkg::step_rsp_t                     step_rsp
);
	import smmv_pkg::*;

	localparam logic [3:0] S_IDLE     = 4'd0;
	localparam logic [3:0] S_SQR      = 4'd1;
	localparam logic [3:0] S_ACC      = 4'd2;
	localparam logic [3:0] S_NSQ      = 4'd3;
	localparam logic [3:0] S_SSQ      = 4'd4;
	localparam logic [3:0] S_NUM      = 4'd5;
	localparam logic [3:0] S_MEAN     = 4'd6;
	localparam logic [3:0] S_MEAN_END = 4'd7;
	localparam logic [3:0] S_VAR      = 4'd8;
	localparam logic [3:0] S_VAR_END  = 4'd9;
	localparam logic [3:0] S_ROOT     = 4'd10;
	localparam logic [3:0] S_DONE     = 4'd11;

	localparam logic signed [SAMPLE_BITS-1:0] SMP_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
	localparam logic signed [SAMPLE_BITS-1:0] SMP_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};

	logic [3:0]                    state_q;
	logic                          last_q;
	logic [CNT_W-1:0]              count_q;
	logic signed [SUM_W-1:0]       sum_q;
	logic [SQS_W-1:0]              sumsq_q;
	logic signed [SAMPLE_BITS-1:0] max_q;
	logic signed [SAMPLE_BITS-1:0] min_q;
	logic                          ovf_q;

	logic signed [SAMPLE_BITS-1:0] smp_q;
	logic signed [PRD_W-1:0]       prod_q;
	logic [NUM_W-1:0]              nss_q;
	logic [NSQ_W-1:0]              nn_q;
	logic [NUM_W-1:0]              num_q;
	logic                          neg_q;
	logic [RAD_W-1:0]              dvd_q;
	logic [UNIT_W-1:0]             rem_q;
	logic [RAD_W-1:0]              qt_q;
	logic [ITER_W-1:0]             iter_q;
	logic signed [MEAN_W-1:0]      mean_q;
	logic [VAR_W-1:0]              var_q;

	logic signed [SUM_W-1:0]      mul_op;
	logic signed [PRD_W-1:0]      mul_p;
	logic signed [SUM_W-1:0]      abs_sum;
	logic [MEAN_STEPS-1:0]        mean_mag;
	logic [MEAN_STEPS-1:0]        mean_full;
	logic                         acc_ok;
	logic [UNIT_W-1:0]            rem_next;

	assign in_ready  = (state_q == S_IDLE);
	assign res_valid = (state_q == S_DONE);
	assign acc_ok    = (count_q < CNT_W'(CAPACITY));

	// one multiplier: squares each sample, then the final sum
	assign mul_op = (state_q == S_SSQ) ? sum_q : SUM_W'(smp_q);
	assign mul_p  = mul_op * mul_op;

	assign abs_sum   = sum_q[SUM_W-1] ? -sum_q : sum_q;
	assign mean_mag  = qt_q[MEAN_STEPS-1:0] + MEAN_STEPS'(rem_q != '0);
	assign mean_full = neg_q ? -mean_mag : qt_q[MEAN_STEPS-1:0];

	always_comb begin
		step_req = '0;
		unique case (state_q)
			S_MEAN: begin
				step_req.a = {rem_q[UNIT_W-2:0], dvd_q[RAD_W-1]};
				step_req.b = UNIT_W'(count_q);
			end
			S_VAR: begin
				step_req.a = {rem_q[UNIT_W-2:0], dvd_q[RAD_W-1]};
				step_req.b = UNIT_W'(nn_q);
			end
			S_ROOT: begin
				step_req.a = {rem_q[UNIT_W-3:0], dvd_q[RAD_W-1:RAD_W-2]};
				step_req.b = {qt_q[UNIT_W-3:0], 2'b01};
			end
			default: step_req = '0;
		endcase
	end

	assign rem_next = step_rsp.ge ? step_rsp.diff : step_req.a;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			last_q  <= 1'b0;
			count_q <= '0;
			sum_q   <= '0;
			sumsq_q <= '0;
			max_q   <= SMP_MIN;
			min_q   <= SMP_MAX;
			ovf_q   <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						last_q  <= in_last;
						state_q <= S_SQR;
					end
				end
				S_SQR: state_q <= S_ACC;
				S_ACC: begin
					if (acc_ok) begin
						count_q <= count_q + CNT_W'(1);
						sum_q   <= sum_q + SUM_W'(smp_q);
						sumsq_q <= sumsq_q + prod_q[SQS_W-1:0];
						if (smp_q > max_q) max_q <= smp_q;
						if (smp_q < min_q) min_q <= smp_q;
					end else begin
						ovf_q <= 1'b1;
					end
					state_q <= last_q ? S_NSQ : S_IDLE;
				end
				S_NSQ:      state_q <= S_SSQ;
				S_SSQ:      state_q <= S_NUM;
				S_NUM:      state_q <= S_MEAN;
				S_MEAN: begin
					if (iter_q == ITER_W'(MEAN_STEPS - 1)) state_q <= S_MEAN_END;
				end
				S_MEAN_END: state_q <= S_VAR;
				S_VAR: begin
					if (iter_q == ITER_W'(VAR_STEPS - 1)) state_q <= S_VAR_END;
				end
				S_VAR_END:  state_q <= S_ROOT;
				S_ROOT: begin
					if (iter_q == ITER_W'(ROOT_STEPS - 1)) state_q <= S_DONE;
				end
				S_DONE: begin
					// hand the result off, then start a fresh set
					if (res_ready) begin
						count_q <= '0;
						sum_q   <= '0;
						sumsq_q <= '0;
						max_q   <= SMP_MIN;
						min_q   <= SMP_MAX;
						ovf_q   <= 1'b0;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) smp_q <= in_sample;
			end
			S_SQR: prod_q <= mul_p;
			S_NSQ: begin
				nss_q <= NUM_W'(count_q) * NUM_W'(sumsq_q);
				nn_q  <= NSQ_W'(count_q) * NSQ_W'(count_q);
			end
			S_SSQ: prod_q <= mul_p;
			S_NUM: begin
				num_q  <= nss_q - prod_q[NUM_W-1:0];
				neg_q  <= sum_q[SUM_W-1];
				dvd_q  <= {abs_sum[SUM_W-2:0], {(RAD_W-SUM_W+1){1'b0}}};
				rem_q  <= '0;
				qt_q   <= '0;
				iter_q <= '0;
			end
			S_MEAN, S_VAR: begin
				rem_q  <= rem_next;
				qt_q   <= {qt_q[RAD_W-2:0], step_rsp.ge};
				dvd_q  <= {dvd_q[RAD_W-2:0], 1'b0};
				iter_q <= iter_q + ITER_W'(1);
			end
			S_MEAN_END: begin
				mean_q <= mean_full[MEAN_W-1:0];
				dvd_q  <= RAD_W'({num_q, {FRAC_BITS{1'b0}}});
				rem_q  <= '0;
				qt_q   <= '0;
				iter_q <= '0;
			end
			S_VAR_END: begin
				var_q  <= qt_q[VAR_W-1:0];
				dvd_q  <= RAD_W'({qt_q[VAR_W-1:0], {FRAC_BITS{1'b0}}});
				rem_q  <= '0;
				qt_q   <= '0;
				iter_q <= '0;
			end
			S_ROOT: begin
				rem_q  <= rem_next;
				qt_q   <= {qt_q[RAD_W-2:0], step_rsp.ge};
				dvd_q  <= {dvd_q[RAD_W-3:0], 2'b00};
				iter_q <= iter_q + ITER_W'(1);
			end
			default: begin
				iter_q <= iter_q;
			end
		endcase
	end

	assign res.largest      = max_q;
	assign res.smallest     = min_q;
	assign res.mean_fx      = mean_q;
	assign res.variance_fx  = var_q;
	assign res.std_dev_fx   = qt_q[STD_W-1:0];
	assign res.sample_count = OCNT_W'(count_q);
	assign res.dropped      = ovf_q;
endmodule

>>> design/set_min_max_mean_variance_top.sv
// Each sample occupies the block while it is accepted, squared and
// accumulated; no new sample is taken before that. The closing sample then
// runs multiply/subtract setup steps, after which the shared subtract unit
// yields one bit per cycle for the mean, the variance and the root.
// Reset (arst_n low, asynchronous) empties the set and the output register.
module set_min_max_mean_variance_top (
	input logic        clk,
	input logic        arst_n,
	smmv_in_if.sink    samples,
	smmv_out_if.source stats
);
	import smmv_pkg::*;

	stats_t    res;
	logic      res_valid;
	logic      res_ready;
	step_req_t step_req;
	step_rsp_t step_rsp;
	logic      out_valid_q;
	stats_t    out_q;

	smmv_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (samples.valid),
		.in_ready  (samples.ready),
		.in_sample (samples.sample),
		.in_last   (samples.is_last),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.step_req  (step_req),
		.step_rsp  (step_rsp)
	);

	smmv_sub u_sub (
		.req (step_req),
		.rsp (step_rsp)
	);

	// output register: the core may start the next set while a result waits
	assign res_ready = !out_valid_q || stats.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) out_q <= res;
	end

	assign stats.valid        = out_valid_q;
	assign stats.largest      = out_q.largest;
	assign stats.smallest     = out_q.smallest;
	assign stats.mean_fx      = out_q.mean_fx;
	assign stats.variance_fx  = out_q.variance_fx;
	assign stats.std_dev_fx   = out_q.std_dev_fx;
	assign stats.sample_count = out_q.sample_count;
	assign stats.dropped      = out_q.dropped;

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(samples.valid && samples.ready) |=> !samples.ready)
		else $error("sample accepted while previous one still in work");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		stats.valid |-> (stats.sample_count != '0 &&
			stats.sample_count <= OCNT_W'(CAPACITY)))
		else $error("sample count out of range");

	a_min_le_max: assert property (@(posedge clk) disable iff (!arst_n)
		stats.valid |-> (stats.smallest <= stats.largest))
		else $error("smallest above largest");

	a_root_floor: assert property (@(posedge clk) disable iff (!arst_n)
		stats.valid |->
			(64'(stats.std_dev_fx) * 64'(stats.std_dev_fx) <=
				64'({stats.variance_fx, 8'h00}) &&
			(64'(stats.std_dev_fx) + 64'd1) * (64'(stats.std_dev_fx) + 64'd1) >
				64'({stats.variance_fx, 8'h00})))
		else $error("standard deviation is not the floor root of the variance");
endmodule

>>> sim/set_min_max_mean_variance_top_tb.sv
`timescale 1ns / 100ps

module set_min_max_mean_variance_top_tb;
	import smmv_pkg::*;

	localparam int CYCLE_LIMIT  = 1_000_000;
	localparam int TARGET_BEATS = 950;
	localparam int DRAIN_CYCLES = 150;
	localparam int PRINT_CAP    = 200;

	typedef struct {
		logic signed [SAMPLE_BITS-1:0] value;
		logic                          is_last;
	} sample_beat_t;

	logic clk = 1'b0;
	logic arst_n;

	smmv_in_if  samples_if ();
	smmv_out_if stats_if ();

	set_min_max_mean_variance_top uut (
		.clk    (clk),
		.arst_n (arst_n),
		.samples(samples_if),
		.stats  (stats_if)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	sample_beat_t pending_beats[$];
	stats_t       expected_stats[$];

	int total_beats    = 0;
	int beats_in       = 0;
	int mismatch_count = 0;
	int cycle_count    = 0;
	int idle_phase;

	// running statistics of the open set
	longint set_count   = 0;
	longint set_sum     = 0;
	longint set_sq_sum  = 0;
	longint set_max     = -(longint'(1) << (SAMPLE_BITS - 1));
	longint set_min     = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
	logic   set_dropped = 1'b0;

	task automatic report_mismatch(input string msg);
		if (mismatch_count < PRINT_CAP)
			$display("%0t: %s", $realtime, msg);
		mismatch_count++;
	endtask

	task automatic clear_set();
		set_count   = 0;
		set_sum     = 0;
		set_sq_sum  = 0;
		set_max     = -(longint'(1) << (SAMPLE_BITS - 1));
		set_min     = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
		set_dropped = 1'b0;
	endtask

	function automatic longint floor_root(input longint x);
		longint root;
		longint trial;
		root = 0;
		for (int b = 31; b >= 0; b--) begin
			trial = root | (longint'(1) << b);
			if (trial * trial <= x)
				root = trial;
		end
		return root;
	endfunction

	task automatic absorb_sample(input sample_beat_t beat);
		longint s;
		longint n;
		longint scaled;
		longint mean;
		longint spread;
		longint var_fx;
		stats_t st;
		s = longint'(beat.value);
		if (set_count < CAPACITY) begin
			set_count++;
			set_sum    += s;
			set_sq_sum += s * s;
			if (s > set_max)
				set_max = s;
			if (s < set_min)
				set_min = s;
		end else begin
			set_dropped = 1'b1;
		end
		if (beat.is_last) begin
			n = set_count;
			scaled = set_sum * 256;
			mean = scaled / n;
			// division truncates toward zero; floor it for negative sums
			if (scaled % n != 0 && scaled < 0)
				mean--;
			spread = n * set_sq_sum - set_sum * set_sum;
			var_fx = (spread * 256) / (n * n);
			st.largest      = SAMPLE_BITS'(set_max);
			st.smallest     = SAMPLE_BITS'(set_min);
			st.mean_fx      = MEAN_W'(mean);
			st.variance_fx  = VAR_W'(var_fx);
			st.std_dev_fx   = STD_W'(floor_root(var_fx * 256));
			st.sample_count = OCNT_W'(n);
			st.dropped      = set_dropped;
			expected_stats.push_back(st);
			clear_set();
		end
	endtask

	task automatic push_beat(input logic signed [SAMPLE_BITS-1:0] value, input logic is_last);
		sample_beat_t beat;
		beat.value   = value;
		beat.is_last = is_last;
		pending_beats.push_back(beat);
	endtask

	function automatic logic signed [SAMPLE_BITS-1:0] draw_value();
		int pick;
		pick = $urandom_range(99);
		if (pick < 10)
			return {1'b1, {(SAMPLE_BITS - 1){1'b0}}};
		else if (pick < 20)
			return {1'b0, {(SAMPLE_BITS - 1){1'b1}}};
		else if (pick < 32)
			return $signed(SAMPLE_BITS'(int'($urandom_range(8)) - 4));
		else
			return $signed(SAMPLE_BITS'($urandom));
	endfunction

	always_comb begin
		if (total_beats == 0 || beats_in < total_beats / 3)
			idle_phase = 0;
		else if (beats_in < 2 * total_beats / 3)
			idle_phase = 1;
		else
			idle_phase = 2;
	end

	// driver: accept the current beat, then present the next one or idle
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			samples_if.valid   <= 1'b0;
			samples_if.sample  <= '0;
			samples_if.is_last <= 1'b0;
		end else begin
			if (samples_if.valid && samples_if.ready) begin
				absorb_sample('{samples_if.sample, samples_if.is_last});
				beats_in++;
			end
			if (!samples_if.valid || samples_if.ready) begin
				if (pending_beats.size() != 0 && $urandom_range(99) >=
						(idle_phase == 0 ? 19 : idle_phase == 1 ? 73 : 0)) begin
					samples_if.valid   <= 1'b1;
					samples_if.sample  <= pending_beats[0].value;
					samples_if.is_last <= pending_beats[0].is_last;
					void'(pending_beats.pop_front());
				end else begin
					samples_if.valid <= 1'b0;
				end
			end
		end
	end

	// monitor: check each result beat against the oldest expectation
	always @(posedge clk or negedge arst_n) begin
		stats_t got;
		stats_t want;
		if (!arst_n) begin
			stats_if.ready <= 1'b0;
		end else begin
			if (stats_if.valid && stats_if.ready) begin
				got.largest      = stats_if.largest;
				got.smallest     = stats_if.smallest;
				got.mean_fx      = stats_if.mean_fx;
				got.variance_fx  = stats_if.variance_fx;
				got.std_dev_fx   = stats_if.std_dev_fx;
				got.sample_count = stats_if.sample_count;
				got.dropped      = stats_if.dropped;
				if (expected_stats.size() == 0) begin
					report_mismatch("result beat with no set closed");
				end else begin
					want = expected_stats.pop_front();
					if (got.largest !== want.largest)
						report_mismatch($sformatf("largest got %0d want %0d",
							got.largest, want.largest));
					if (got.smallest !== want.smallest)
						report_mismatch($sformatf("smallest got %0d want %0d",
							got.smallest, want.smallest));
					if (got.mean_fx !== want.mean_fx)
						report_mismatch($sformatf("mean_fx got %0d want %0d",
							got.mean_fx, want.mean_fx));
					if (got.variance_fx !== want.variance_fx)
						report_mismatch($sformatf("variance_fx got %0d want %0d",
							got.variance_fx, want.variance_fx));
					if (got.std_dev_fx !== want.std_dev_fx)
						report_mismatch($sformatf("std_dev_fx got %0d want %0d",
							got.std_dev_fx, want.std_dev_fx));
					if (got.sample_count !== want.sample_count)
						report_mismatch($sformatf("sample_count got %0d want %0d",
							got.sample_count, want.sample_count));
					if (got.dropped !== want.dropped)
						report_mismatch($sformatf("dropped got %0b want %0b",
							got.dropped, want.dropped));
				end
			end
			stats_if.ready <= $urandom_range(99) >=
				(idle_phase == 0 ? 73 : idle_phase == 1 ? 19 : 0);
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin
		int set_len;
		arst_n = 1'b0;

		// single-sample sets at the extremes and at zero
		push_beat(16'sh8000, 1'b1);
		push_beat(16'sh7fff, 1'b1);
		push_beat(16'sh0000, 1'b1);
		// full set of alternating extremes, closing sample beyond capacity
		for (int i = 0; i < CAPACITY + 1; i++)
			push_beat(i[0] ? 16'sh7fff : 16'sh8000, i == CAPACITY);

		while (pending_beats.size() < TARGET_BEATS) begin
			if ($urandom_range(99) < 85)
				set_len = $urandom_range(CAPACITY, 1);
			else
				set_len = $urandom_range(CAPACITY + 6, CAPACITY + 1);
			for (int i = 0; i < set_len; i++)
				push_beat(draw_value(), i == set_len - 1);
		end
		total_beats = pending_beats.size();

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		wait (beats_in == total_beats);
		wait (expected_stats.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatch_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

>>> sim.f
design/smmv_pkg.sv
design/smmv_if.sv
design/smmv_sub.sv
design/smmv_core.sv
design/set_min_max_mean_variance_top.sv
sim/set_min_max_mean_variance_top_tb.sv
